>>> rtl/core/uet_pkg.sv
// ----------------------------------------------------------------------------
// uet_pkg
// Shared types and constants for the ultrasonic echo timer.
// ----------------------------------------------------------------------------
package uet_pkg;

	localparam int LOW_W = 8;
	localparam int PW_W  = 8;
	localparam int TMO_W = 20;
	localparam int DUR_W = 21;
	localparam int CFG_W = 20;
	localparam int IDX_W = 2;

	// register indexes
	localparam logic [IDX_W-1:0] REG_TRIG_LOW   = 2'd0;
	localparam logic [IDX_W-1:0] REG_PW_SHARED  = 2'd1;
	localparam logic [IDX_W-1:0] REG_PW_SEP     = 2'd2;
	localparam logic [IDX_W-1:0] REG_TIMEOUT    = 2'd3;

	// reset values of the registers
	localparam logic [LOW_W-1:0] RST_TRIG_LOW  = 8'd2;
	localparam logic [PW_W-1:0]  RST_PW_SHARED = 8'd5;
	localparam logic [PW_W-1:0]  RST_PW_SEP    = 8'd10;
	localparam logic [TMO_W-1:0] RST_TIMEOUT   = 20'd30000;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TRIG_LOW,
		PH_TRIG_HIGH,
		PH_WAIT_RISE,
		PH_WAIT_FALL
	} phase_t;

	typedef struct packed {
		logic [LOW_W-1:0] trigger_low_ticks;
		logic [PW_W-1:0]  pulse_width_shared_pin;
		logic [PW_W-1:0]  pulse_width_separate_pins;
		logic [TMO_W-1:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic             trigger_level;
		logic             trigger_drive;
		logic             busy_res;
		logic             done_res;
		logic [DUR_W-1:0] echo_duration;
	} res_t;

endpackage

>>> rtl/core/ultrasonic_echo_timer.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_timer
// Trigger pulse generator and echo width timer for one ultrasonic sensor.
// ----------------------------------------------------------------------------
// Pipeline: a tick word is captured in the input register, and its result word is
// then loaded into the result register once that register is free or drains.
// Throughput: one tick word per cycle unless out_stall holds a full result register, set by the sequencer update
// between the input register and the result register.
// Reset: idle phase, counter zero, shared-pin kind, registers at 2/5/10/30000,
// both pipeline stages empty.
// ----------------------------------------------------------------------------
module ultrasonic_echo_timer #(
	parameter int COUNTER_BITS = 21
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [uet_pkg::IDX_W-1:0]   cfg_index,
	input  logic [uet_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        start_req,
	input  logic                        separate_pins,
	input  logic                        echo_level,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        trigger_level,
	output logic                        trigger_drive,
	output logic                        busy_res,
	output logic                        done_res,
	output logic [uet_pkg::DUR_W-1:0]   echo_duration
);
	import uet_pkg::*;

	cfg_t                    cfg;
	phase_t                  phase_q, phase_nxt;
	logic [COUNTER_BITS-1:0] cnt_q, cnt_nxt;
	logic                    kind_q, kind_nxt;
	logic                    valid_s1, valid_s2, adv1, in_acc;
	logic                    start_s1, sep_s1, echo_s1;
	res_t                    res, res_s2;

	uet_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	uet_step #(.COUNTER_BITS(COUNTER_BITS)) u_step (
		.cfg           (cfg),
		.phase         (phase_q),
		.cnt           (cnt_q),
		.kind          (kind_q),
		.start_req     (start_s1),
		.separate_pins (sep_s1),
		.echo_level    (echo_s1),
		.phase_nxt     (phase_nxt),
		.cnt_nxt       (cnt_nxt),
		.kind_nxt      (kind_nxt),
		.res           (res)
	);

	// advance the input stage when the result register is free or drains
	assign adv1     = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv1;
	assign in_acc   = in_valid && !in_stall;

	// stage valids and sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			phase_q  <= PH_IDLE;
			cnt_q    <= '0;
			kind_q   <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv1) begin
				valid_s1 <= 1'b0;
			end
			if (adv1) begin
				valid_s2 <= 1'b1;
				phase_q  <= phase_nxt;
				cnt_q    <= cnt_nxt;
				kind_q   <= kind_nxt;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// capture input word and result word
	always_ff @(posedge clk) begin
		if (in_acc) begin
			start_s1 <= start_req;
			sep_s1   <= separate_pins;
			echo_s1  <= echo_level;
		end
		if (adv1) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign trigger_level = res_s2.trigger_level;
	assign trigger_drive = res_s2.trigger_drive;
	assign busy_res      = res_s2.busy_res;
	assign done_res      = res_s2.done_res;
	assign echo_duration = res_s2.echo_duration;

	// idle always leaves the counter cleared
	a_idle_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> cnt_q == '0)
		else $error("counter not cleared in idle");

	// a finished measurement is never reported busy
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.done_res |-> !res_s2.busy_res)
		else $error("done reported while busy");

	// duration only travels with done
	a_dur_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.echo_duration != '0 |-> res_s2.done_res)
		else $error("duration without done");

	// busy in the result word follows the state it was loaded with
	a_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv1 |=> res_s2.busy_res == (phase_q != PH_IDLE))
		else $error("busy does not match sequencer state");

endmodule

>>> rtl/core/uet_cfg.sv
// ----------------------------------------------------------------------------
// uet_cfg
// Configuration register file: decodes writes and masks each register.
// ----------------------------------------------------------------------------
module uet_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       we,
	input  logic [uet_pkg::IDX_W-1:0]  index,
	input  logic [uet_pkg::CFG_W-1:0]  wdata,
	output uet_pkg::cfg_t              cfg
);
	import uet_pkg::*;

	cfg_t cfg_q;

	// write the addressed register, keep only its own bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_low_ticks         <= RST_TRIG_LOW;
			cfg_q.pulse_width_shared_pin    <= RST_PW_SHARED;
			cfg_q.pulse_width_separate_pins <= RST_PW_SEP;
			cfg_q.timeout_ticks             <= RST_TIMEOUT;
		end else if (we) begin
			unique case (index)
				REG_TRIG_LOW:  cfg_q.trigger_low_ticks         <= wdata[LOW_W-1:0];
				REG_PW_SHARED: cfg_q.pulse_width_shared_pin    <= wdata[PW_W-1:0];
				REG_PW_SEP:    cfg_q.pulse_width_separate_pins <= wdata[PW_W-1:0];
				REG_TIMEOUT:   cfg_q.timeout_ticks             <= wdata[TMO_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/uet_step.sv
// ----------------------------------------------------------------------------
// uet_step
// One microsecond tick of the ranging sequencer: next state and result word.
// ----------------------------------------------------------------------------
module uet_step #(
	parameter int COUNTER_BITS = 21
) (
	input  uet_pkg::cfg_t            cfg,
	input  uet_pkg::phase_t          phase,
	input  logic [COUNTER_BITS-1:0]  cnt,
	input  logic                     kind,
	input  logic                     start_req,
	input  logic                     separate_pins,
	input  logic                     echo_level,
	output uet_pkg::phase_t          phase_nxt,
	output logic [COUNTER_BITS-1:0]  cnt_nxt,
	output logic                     kind_nxt,
	output uet_pkg::res_t            res
);
	import uet_pkg::*;

	localparam int LIM_W = (COUNTER_BITS > TMO_W) ? COUNTER_BITS : TMO_W;
	localparam int CW_W  = (COUNTER_BITS > DUR_W) ? COUNTER_BITS : DUR_W;
	localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

	phase_t                  ph0, ph1, ph2;
	logic [COUNTER_BITS-1:0] cnt0, cnt1, cnt2, cnt_inc;
	logic [PW_W-1:0]         width;
	logic [LIM_W-1:0]        lim, cap, tmo_ext;
	logic                    low_done, high_done;
	logic                    rise_to, fall_end, fall_to;
	logic [CW_W-1:0]         cnt_wide;

	// a start restarts the run and samples the sensor kind
	assign kind_nxt = start_req ? separate_pins : kind;
	assign ph0      = start_req ? PH_TRIG_LOW : phase;
	assign cnt0     = start_req ? '0 : cnt;
	assign width    = kind_nxt ? cfg.pulse_width_separate_pins : cfg.pulse_width_shared_pin;

	// trigger phases fall through in the same tick once their length is met
	assign low_done  = (ph0 == PH_TRIG_LOW) &&
		(cnt0 >= COUNTER_BITS'(cfg.trigger_low_ticks));
	assign ph1       = low_done ? PH_TRIG_HIGH : ph0;
	assign cnt1      = low_done ? '0 : cnt0;
	assign high_done = (ph1 == PH_TRIG_HIGH) && (cnt1 >= COUNTER_BITS'(width));
	assign ph2       = high_done ? PH_WAIT_RISE : ph1;
	assign cnt2      = high_done ? '0 : cnt1;

	// saturating count and timeout clipped below the counter maximum
	assign cnt_inc = (cnt2 == CNT_MAX) ? cnt2 : cnt2 + COUNTER_BITS'(1);
	assign tmo_ext = LIM_W'(cfg.timeout_ticks);
	assign cap     = LIM_W'(CNT_MAX) - LIM_W'(1);
	assign lim     = (tmo_ext > cap) ? cap : tmo_ext;

	// end conditions of the two waits
	assign rise_to  = (ph2 == PH_WAIT_RISE) &&
		(echo_level ? (lim == '0) : (LIM_W'(cnt_inc) > lim));
	assign fall_end = (ph2 == PH_WAIT_FALL) && !echo_level;
	assign fall_to  = (ph2 == PH_WAIT_FALL) && echo_level && (LIM_W'(cnt_inc) > lim);

	// next state
	always_comb begin
		phase_nxt = ph2;
		cnt_nxt   = cnt2;
		unique case (ph2)
			PH_IDLE: ;
			PH_TRIG_LOW, PH_TRIG_HIGH: begin
				cnt_nxt = cnt_inc;
			end
			PH_WAIT_RISE: begin
				if (rise_to) begin
					phase_nxt = PH_IDLE;
					cnt_nxt   = '0;
				end else if (echo_level) begin
					phase_nxt = PH_WAIT_FALL;
					cnt_nxt   = COUNTER_BITS'(1);
				end else begin
					cnt_nxt = cnt_inc;
				end
			end
			PH_WAIT_FALL: begin
				if (fall_end || fall_to) begin
					phase_nxt = PH_IDLE;
					cnt_nxt   = '0;
				end else begin
					cnt_nxt = cnt_inc;
				end
			end
			default: begin
				phase_nxt = PH_IDLE;
				cnt_nxt   = '0;
			end
		endcase
	end

	assign cnt_wide = CW_W'(cnt2);

	// result word
	always_comb begin
		res               = '0;
		res.trigger_level = (ph2 == PH_TRIG_HIGH);
		res.busy_res      = (phase_nxt != PH_IDLE);
		res.done_res      = rise_to || fall_end || fall_to;
		res.echo_duration = fall_end ? cnt_wide[DUR_W-1:0] : '0;
		unique case (ph2)
			PH_TRIG_LOW, PH_TRIG_HIGH: res.trigger_drive = 1'b1;
			PH_WAIT_RISE, PH_WAIT_FALL: res.trigger_drive = kind_nxt;
			default: res.trigger_drive = kind;
		endcase
	end

endmodule
